// ===== hw/rtl/kmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared constants, codes and types for the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kmsd_pkg;

    // Matrix geometry
    localparam int ROWS  = 4;
    localparam int COLS  = 4;
    localparam int KEY_W = 16;            // width of the closed-switch snapshot
    localparam int POS_N = ROWS * COLS;   // matrix positions

    // Key codes and masks
    localparam logic [7:0] NO_KEY   = 8'hff;
    localparam logic [7:0] ROW_MASK = 8'hf0;
    localparam logic [7:0] COL_MASK = 8'h0f;

    // Operation codes carried in tuser
    localparam logic OP_COL_IRQ    = 1'b0;
    localparam logic OP_TIMER_TICK = 1'b1;

    // Debounce state machine, one-hot
    typedef enum logic [2:0] {
        ST_IDLE      = 3'b001,
        ST_PRESSED   = 3'b010,
        ST_RELEASING = 3'b100
    } t_state;

    // Scan results for both orders
    typedef struct packed {
        logic [7:0] fwd_code;   // first closed key, forward order
        logic [7:0] rev_code;   // first closed key, reverse order
        logic       any_closed;
    } t_scan;

    // One result item
    typedef struct packed {
        logic       report_valid;
        logic [5:0] key_code;
        logic       key_down;
        logic       buzzer_pulse;
        logic       irq_armed;
        logic       timer_running;
    } t_result;

endpackage

// ===== hw/rtl/keypad_matrix_scan_debounce_core.sv =====
// An accepted item is registered in the input register, passes the scan and state
// logic and is registered in the result register when that register is free.
// Throughput: one item per cycle while the master side accepts results; the single pass
// through scan and state logic sits between the input register and the result register.
// Reset (i_rst_n low, synchronous): state machine idle, held key none (0xff),
// next scan forward, both pipeline registers empty.
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce_core
// Matrix keypad scanner with debounce, stream in, stream out.
// ----------------------------------------------------------------------------
module keypad_matrix_scan_debounce_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] key_matrix
    input  logic        i_s_tuser,   // [0] operation
    // Master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [0] report_valid, [6:1] key_code,
                                     // [7] buzzer_pulse, [8] irq_armed,
                                     // [9] timer_running, [15:10] zero
    output logic        o_m_tuser    // [0] key_down
);
    import kmsd_pkg::*;

    logic             r_in_valid;
    logic             r_in_op;
    logic [KEY_W-1:0] r_in_matrix;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_out_load;
    logic             w_step;
    t_scan            w_scan;
    t_result          w_result;

    // Handshake: result register frees when empty or taken
    assign w_out_load = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_load;
    assign o_s_tready = !r_in_valid || w_out_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op     <= i_s_tuser;
            r_in_matrix <= i_s_tdata;
        end
    end

    kmsd_scan u_scan (
        .i_matrix (r_in_matrix),
        .o_scan   (w_scan)
    );

    kmsd_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_op     (r_in_op),
        .i_scan   (w_scan),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    // Pack the master side
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.timer_running, r_out.irq_armed,
                         r_out.buzzer_pulse, r_out.key_code, r_out.report_valid};
    assign o_m_tuser  = r_out.key_down;

endmodule

// ===== hw/rtl/kmsd_scan.sv =====
// ----------------------------------------------------------------------------
// kmsd_scan
// Priority encoders over the closed-switch snapshot, both scan orders.
// ----------------------------------------------------------------------------
module kmsd_scan (
    input  logic [kmsd_pkg::KEY_W-1:0] i_matrix,
    output kmsd_pkg::t_scan            o_scan
);
    import kmsd_pkg::*;

    logic [POS_N-1:0] w_closed;

    // Positions beyond the snapshot read as open
    always_comb begin
        for (int i = 0; i < POS_N; i++) begin
            w_closed[i] = (i < KEY_W) ? i_matrix[4'(i)] : 1'b0;
        end
    end

    // Forward takes the lowest closed position, reverse the highest
    always_comb begin
        logic found;
        found           = 1'b0;
        o_scan.fwd_code = NO_KEY;
        o_scan.rev_code = NO_KEY;
        for (int i = 0; i < POS_N; i++) begin
            if (w_closed[i]) begin
                if (!found) begin
                    o_scan.fwd_code = {4'(i / COLS), 4'(i % COLS)};
                end
                o_scan.rev_code = {4'(i / COLS), 4'(i % COLS)};
                found           = 1'b1;
            end
        end
        o_scan.any_closed = found;
    end

endmodule

// ===== hw/rtl/kmsd_fsm.sv =====
// ----------------------------------------------------------------------------
// kmsd_fsm
// Debounce state machine: held key, scan order and result for one item.
// ----------------------------------------------------------------------------
module kmsd_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,      // item moves to the result register
    input  logic              i_op,
    input  kmsd_pkg::t_scan   i_scan,
    output kmsd_pkg::t_result o_result
);
    import kmsd_pkg::*;

    t_state     r_state, n_state;
    logic [7:0] r_held,  n_held;
    logic       r_rev,   n_rev;

    logic [7:0] w_scan_code;
    logic       w_held_in;
    logic [5:0] w_held_code;

    // Scan in the current order
    assign w_scan_code = r_rev ? i_scan.rev_code : i_scan.fwd_code;

    // Held key inside the matrix, and its reported code
    assign w_held_in   = (((r_held & ROW_MASK) >> 4) < 8'(ROWS)) &&
                         ((r_held & COL_MASK) < 8'(COLS));
    assign w_held_code = 6'(r_held + 8'd1);

    // Next state and result
    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_rev    = r_rev;
        o_result = '0;
        if (i_op == OP_COL_IRQ) begin
            n_state                = ST_IDLE;
            n_held                 = w_scan_code;
            n_rev                  = ~r_rev;
            o_result.timer_running = 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    n_rev = ~r_rev;
                    if (w_scan_code == r_held && r_held != NO_KEY) begin
                        n_state                = ST_PRESSED;
                        o_result.timer_running = 1'b1;
                        if (w_held_in) begin
                            o_result.report_valid = 1'b1;
                            o_result.key_code     = w_held_code;
                            o_result.key_down     = 1'b1;
                            o_result.buzzer_pulse = 1'b1;
                        end
                    end else begin
                        o_result.irq_armed = 1'b1;
                    end
                end
                ST_PRESSED: begin
                    n_rev                  = ~r_rev;
                    o_result.timer_running = 1'b1;
                    if (w_scan_code != r_held) begin
                        n_state = ST_RELEASING;
                        if (w_held_in) begin
                            o_result.report_valid = 1'b1;
                            o_result.key_code     = w_held_code;
                        end
                    end
                end
                ST_RELEASING: begin
                    if (!i_scan.any_closed) begin
                        n_state            = ST_IDLE;
                        o_result.irq_armed = 1'b1;
                    end else begin
                        o_result.timer_running = 1'b1;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    // State registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= NO_KEY;
            r_rev   <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_held  <= n_held;
            r_rev   <= n_rev;
        end
    end

endmodule
